// ===== rtl/biquad_cascade_band_core_assert.svh =====
// Assertion macros for the biquad cascade band core.
// A module that uses them must have ports or signals named aclk and aresetn.
`ifndef BIQUAD_CASCADE_BAND_CORE_ASSERT_SVH
`define BIQUAD_CASCADE_BAND_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BCB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bcb same-cycle check failed");
`define BCB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bcb next-cycle check failed");
`else
`define BCB_ASSERT_IMP(label, ante, cons)
`define BCB_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/bcb_pkg.sv =====
`default_nettype none
package bcb_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int CHANNELS_DEF  = 2;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int HIST_W    = 48;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = 62;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int Y_SHIFT   = 28;
    localparam int S_SHIFT   = 12;

    localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(1) << (Y_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] RND_S = ACC_W'(1) << (S_SHIFT - 1);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_COUNT  = 3'd5,
        REG_BYPASS = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MB0,
        ST_MB1,
        ST_Y,
        ST_MA1,
        ST_MA2,
        ST_N1,
        ST_N2,
        ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MB0,
        OP_MB1,
        OP_Y,
        OP_MA1,
        OP_MA2,
        OP_N1,
        OP_N2
    } step_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_t;

    typedef struct packed {
        step_t step;
        logic  load_in;
        logic  hist_valid;
    } dp_ctrl_t;

    // Round-shifted accumulator to Q1.23 with saturation.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-Y_SHIFT-SAMPLE_W:0] hi;
        logic signed [SAMPLE_W-1:0]      r;
        hi = v[ACC_W-1:Y_SHIFT+SAMPLE_W-1];
        if ((&hi) || !(|hi)) begin
            r = v[Y_SHIFT+SAMPLE_W-1:Y_SHIFT];
        end else begin
            r = v[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [HIST_W-1:0] sat_hist(
        input logic signed [HIST_W:0] v
    );
        logic signed [HIST_W-1:0] r;
        if (v[HIST_W] == v[HIST_W-1]) begin
            r = v[HIST_W-1:0];
        end else begin
            r = v[HIST_W] ? HIST_MIN : HIST_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bcb_hist_mem.sv =====
`default_nettype none
module bcb_hist_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int W     = 96
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [W-1:0]  rd_data,
    input  wire logic          we,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [W-1:0]  wr_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/bcb_datapath.sv =====
`default_nettype none
module bcb_datapath (
    input  wire logic                                   aclk,
    input  wire bcb_pkg::dp_ctrl_t                      ctrl,
    input  wire bcb_pkg::coef_t                         coef,
    input  wire logic signed [bcb_pkg::SAMPLE_W-1:0]    in_sample,
    input  wire logic        [2*bcb_pkg::HIST_W-1:0]    rd_data,
    output logic             [2*bcb_pkg::HIST_W-1:0]    wr_data,
    output logic signed      [bcb_pkg::SAMPLE_W-1:0]    result
);
    import bcb_pkg::*;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc1_reg;
    logic signed [ACC_W-1:0]    acc2_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [HIST_W-1:0]   n1_reg;
    logic signed [HIST_W-1:0]   h1;
    logic signed [HIST_W-1:0]   h2;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    h1_ext;
    logic signed [HIST_W:0]     n1_sum;
    logic signed [HIST_W-1:0]   n2;

    // An entry not written since its last clear reads as zero history.
    assign h1 = ctrl.hist_valid ? $signed(rd_data[HIST_W-1:0]) : '0;
    assign h2 = ctrl.hist_valid ? $signed(rd_data[2*HIST_W-1:HIST_W]) : '0;

    always_comb begin
        case (ctrl.step)
            OP_MB1:  mul_a = coef.b1;
            OP_Y:    mul_a = coef.b2;
            OP_MA1:  mul_a = coef.a1;
            OP_MA2:  mul_a = coef.a2;
            default: mul_a = coef.b0;
        endcase
        mul_b = (ctrl.step == OP_MA1 || ctrl.step == OP_MA2) ? y_reg : x_reg;
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign h1_ext   = ACC_W'(h1) <<< S_SHIFT;
    assign n1_sum   = $signed(acc1_reg[HIST_W+S_SHIFT:S_SHIFT]) + (HIST_W+1)'(h2);
    assign n2       = acc2_reg[HIST_W+S_SHIFT-1:S_SHIFT];

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (ctrl.step)
            OP_MB1: acc1_reg <= prod_ext + h1_ext + RND_Y;
            OP_Y: begin
                y_reg    <= sat_sample(acc1_reg);
                acc1_reg <= prod_ext + RND_S;
            end
            OP_MA1: acc2_reg <= prod_ext + RND_S;
            OP_MA2: acc1_reg <= acc1_reg - prod_ext;
            OP_N1: begin
                n1_reg   <= sat_hist(n1_sum);
                acc2_reg <= acc2_reg - prod_ext;
            end
            OP_N2:  x_reg <= y_reg;
            default: ;
        endcase
        if (ctrl.load_in) begin
            x_reg <= in_sample;
        end
    end

    assign wr_data = {n2, n1_reg};
    assign result  = x_reg;

endmodule
`default_nettype wire

// ===== rtl/bcb_seq.sv =====
`default_nettype none
`include "biquad_cascade_band_core_assert.svh"
module bcb_seq #(
    parameter int MAX_ORDER = 4,
    parameter int CHANNELS  = 2,
    parameter int DEPTH     = 8,
    parameter int AW        = 3
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_fire,
    input  wire logic                         in_channel,
    input  wire logic                         cfg_bypass,
    input  wire logic [bcb_pkg::CNT_W-1:0]    cfg_count,
    input  wire logic                         out_free,
    output logic                              in_ready,
    output logic                              done,
    output logic                              out_channel,
    output bcb_pkg::dp_ctrl_t                 ctrl,
    output logic                              mem_rd_en,
    output logic      [AW-1:0]                mem_rd_addr,
    output logic                              mem_we,
    output logic      [AW-1:0]                mem_wr_addr
);
    import bcb_pkg::*;

    localparam int SW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int OW = $clog2(MAX_ORDER + 1);

    seq_state_t       state_reg, state_next;
    logic [SW-1:0]    sec_reg, sec_next;
    logic [OW-1:0]    order_reg, order_next;
    logic [OW-1:0]    active_reg, active_next;
    logic             ch_reg, ch_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             hv_reg, hv_next;
    logic [OW-1:0]    order_eff;
    logic             chan_ok;
    logic             more;
    wire  [DEPTH-1:0] sec_clr;

    function automatic logic [AW-1:0] hist_addr(input logic ch, input logic [SW-1:0] s);
        return AW'(int'(ch) * MAX_ORDER + int'(s));
    endfunction

    always_comb begin
        if (cfg_count == '0) begin
            order_eff = OW'(1);
        end else if (int'(cfg_count) > MAX_ORDER) begin
            order_eff = OW'(MAX_ORDER);
        end else begin
            order_eff = OW'(cfg_count);
        end
    end

    assign chan_ok = int'(in_channel) < CHANNELS;
    assign more    = (OW'(sec_reg) + OW'(1)) < order_reg;

    // Sections added since the last item lose their history on every channel.
    for (genvar e = 0; e < DEPTH; e++) begin : g_clr
        localparam int ESEC = e % MAX_ORDER;
        assign sec_clr[e] = (ESEC >= int'(active_reg)) && (ESEC < int'(order_eff));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (cfg_bypass || !chan_ok) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: state_next = ST_MB0;
            ST_MB0:  state_next = ST_MB1;
            ST_MB1:  state_next = ST_Y;
            ST_Y:    state_next = ST_MA1;
            ST_MA1:  state_next = ST_MA2;
            ST_MA2:  state_next = ST_N1;
            ST_N1:   state_next = ST_N2;
            ST_N2:   state_next = more ? ST_MB0 : ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready    = 1'b0;
        done        = 1'b0;
        mem_rd_en   = 1'b0;
        mem_we      = 1'b0;
        ctrl.step   = OP_IDLE;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: mem_rd_en = 1'b1;
            ST_MB0:  ctrl.step = OP_MB0;
            ST_MB1:  ctrl.step = OP_MB1;
            ST_Y:    ctrl.step = OP_Y;
            ST_MA1:  ctrl.step = OP_MA1;
            ST_MA2:  ctrl.step = OP_MA2;
            ST_N1: begin
                ctrl.step = OP_N1;
                mem_rd_en = more;
            end
            ST_N2: begin
                ctrl.step = OP_N2;
                mem_we    = 1'b1;
            end
            ST_DONE: done = out_free;
            default: ;
        endcase
        ctrl.load_in    = in_fire;
        ctrl.hist_valid = hv_reg;
        mem_rd_addr = (state_reg == ST_READ) ? hist_addr(ch_reg, '0)
                                             : hist_addr(ch_reg, sec_reg + SW'(1));
        mem_wr_addr = hist_addr(ch_reg, sec_reg);
        out_channel = ch_reg;
    end

    always_comb begin
        sec_next    = sec_reg;
        order_next  = order_reg;
        active_next = active_reg;
        ch_next     = ch_reg;
        hv_next     = hv_reg;
        valid_next  = valid_reg;
        if (in_fire) begin
            ch_next     = in_channel;
            order_next  = order_eff;
            sec_next    = '0;
            active_next = cfg_bypass ? '0 : order_eff;
            valid_next  = cfg_bypass ? '0 : (valid_reg & ~sec_clr);
        end
        if (state_reg == ST_N2 && more) begin
            sec_next = sec_reg + SW'(1);
        end
        if (mem_we) begin
            valid_next[mem_wr_addr] = 1'b1;
        end
        if (mem_rd_en) begin
            hv_next = valid_reg[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sec_reg    <= '0;
            order_reg  <= OW'(1);
            active_reg <= '0;
            ch_reg     <= 1'b0;
            valid_reg  <= '0;
            hv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sec_reg    <= sec_next;
            order_reg  <= order_next;
            active_reg <= active_next;
            ch_reg     <= ch_next;
            valid_reg  <= valid_next;
            hv_reg     <= hv_next;
        end
    end

    `BCB_ASSERT_NXT(a_bypass_clears, in_fire && cfg_bypass, valid_reg == '0 && active_reg == '0)
    `BCB_ASSERT_IMP(a_write_in_band, mem_we, OW'(sec_reg) < order_reg)
    `BCB_ASSERT_IMP(a_no_accept_busy, mem_we || mem_rd_en, !in_ready)
    `BCB_ASSERT_NXT(a_done_to_idle, done, state_reg == ST_IDLE && in_ready)

endmodule
`default_nettype wire

// ===== rtl/biquad_cascade_band_core.sv =====
`default_nettype none
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample_in; tuser: channel_in
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: sample_out; tuser: channel_out
// cfg       in   cfg_valid/cfg_ready          cfg_index: register, cfg_data: value
//
// From one input transfer to the next, a filtered item passes through one history
// read, then the steps MB0, MB1, Y, MA1, MA2, N1 and N2 for each section, in
// which the single 32x24 multiplier forms the five products of that section.
// Bypassed items and channels beyond CHANNELS skip straight to the done state.
// aresetn is synchronous, active low; reset loads the register defaults and
// marks all history as zero. The result sits in an output register, so a
// stalled m_axis holds the block in its done state only, with s_axis_tready low.
module biquad_cascade_band_core #(
    parameter int MAX_ORDER = bcb_pkg::MAX_ORDER_DEF,
    parameter int CHANNELS  = bcb_pkg::CHANNELS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input samples
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [bcb_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [23:0] sample_in
    input  wire logic                              s_axis_tuser,  // [0] channel_in
    // filtered samples
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [bcb_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [23:0] sample_out
    output logic                                   m_axis_tuser,  // [0] channel_out
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bcb_pkg::COEF_W-1:0]        cfg_data
);
    import bcb_pkg::*;

    localparam int DEPTH = CHANNELS * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W = 2 * HIST_W;

    coef_t                      coef_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       bypass_reg;
    logic                       in_fire;
    logic                       out_free;
    logic                       done;
    logic                       out_channel;
    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic                       m_user_reg;
    dp_ctrl_t                   ctrl;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic                       mem_we;
    logic [AW-1:0]              mem_wr_addr;
    logic [MEM_W-1:0]           rd_data;
    logic [MEM_W-1:0]           wr_data;
    logic signed [SAMPLE_W-1:0] result;

    // Registers take a write on any cycle; the user writes only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
            count_reg   <= CNT_W'(1);
            bypass_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_B0:     coef_reg.b0 <= $signed(cfg_data);
                REG_B1:     coef_reg.b1 <= $signed(cfg_data);
                REG_B2:     coef_reg.b2 <= $signed(cfg_data);
                REG_A1:     coef_reg.a1 <= $signed(cfg_data);
                REG_A2:     coef_reg.a2 <= $signed(cfg_data);
                REG_COUNT:  count_reg   <= cfg_data[CNT_W-1:0];
                REG_BYPASS: bypass_reg  <= cfg_data[0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    // Output slot is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;

    bcb_seq #(
        .MAX_ORDER (MAX_ORDER),
        .CHANNELS  (CHANNELS),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_channel  (s_axis_tuser),
        .cfg_bypass  (bypass_reg),
        .cfg_count   (count_reg),
        .out_free    (out_free),
        .in_ready    (s_axis_tready),
        .done        (done),
        .out_channel (out_channel),
        .ctrl        (ctrl),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_we      (mem_we),
        .mem_wr_addr (mem_wr_addr)
    );

    // History per channel and section: {s2, s1}.
    bcb_hist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (MEM_W)
    ) u_hist_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (wr_data)
    );

    bcb_datapath u_datapath (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .coef      (coef_reg),
        .in_sample ($signed(s_axis_tdata)),
        .rd_data   (rd_data),
        .wr_data   (wr_data),
        .result    (result)
    );

    // Hold the result until the downstream transfer; load a new one on done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= result;
            m_user_reg <= out_channel;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
`default_nettype wire

// ===== bench/biquad_cascade_band_core_tb.sv =====
`default_nettype none
module biquad_cascade_band_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcb_pkg::*;

    localparam int SECTIONS     = MAX_ORDER_DEF;
    localparam int CHANNEL_NUM  = CHANNELS_DEF;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 128;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 40;
    // Worst legal run is roughly 1556 items, each taking a full filtered pass plus the
    // longest feed gap and the longest output stall; allow about four times that.
    localparam int CYCLE_LIMIT  = 1_000_000;

    // One sample as it travels on either stream: the sample in tdata, the channel in tuser.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
    } band_sample_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;   // [23:0] sample_in
    logic                 s_axis_tuser  = 1'b0; // [0] channel_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]  m_axis_tdata;         // [23:0] sample_out
    logic                 m_axis_tuser;         // [0] channel_out
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_B0;
    logic [COEF_W-1:0]    cfg_data      = '0;

    // Samples waiting to be offered, and filtered samples waiting to come back.
    band_sample_t samples_to_send[$];
    band_sample_t filtered_due[$];

    // Mirror of the register file, updated on each cfg transfer.
    logic signed [COEF_W-1:0] tap_b0 = B0_RESET;
    logic signed [COEF_W-1:0] tap_b1 = '0;
    logic signed [COEF_W-1:0] tap_b2 = '0;
    logic signed [COEF_W-1:0] fb_a1  = '0;
    logic signed [COEF_W-1:0] fb_a2  = '0;
    logic [CNT_W-1:0]         stage_count  = 3'd1;
    logic                     pass_through = 1'b1;

    // Predicted filter state: the two transposed-form delay words per channel and section.
    logic signed [HIST_W-1:0] delay_s1 [CHANNEL_NUM][SECTIONS];
    logic signed [HIST_W-1:0] delay_s2 [CHANNEL_NUM][SECTIONS];
    int                       stages_in_use = 0;

    // Traffic shaping, set per phase by the stimulus process.
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int feed_gap  = 0;
    int sink_gap  = 0;
    bit hold_req  = 1'b0;
    bit hold_req_d = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    biquad_cascade_band_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Add half an LSB of the kept part, then drop k bits arithmetically.
    function automatic longint round_half_up(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint saturate(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One transposed direct form II biquad; products are in units of 2^-51,
    // delay words in units of 2^-39. The saturated output drives the feedback.
    function automatic longint run_biquad(int ch, int sec, longint x);
        longint y;
        longint n1;
        longint n2;
        y  = saturate(round_half_up(longint'(tap_b0) * x
                                    + longint'(delay_s1[ch][sec]) * 4096, Y_SHIFT), SAMPLE_W);
        n1 = saturate(round_half_up(longint'(tap_b1) * x - longint'(fb_a1) * y, S_SHIFT)
                      + longint'(delay_s2[ch][sec]), HIST_W);
        n2 = saturate(round_half_up(longint'(tap_b2) * x - longint'(fb_a2) * y, S_SHIFT),
                      HIST_W);
        delay_s1[ch][sec] = n1[HIST_W-1:0];
        delay_s2[ch][sec] = n2[HIST_W-1:0];
        return y;
    endfunction

    function automatic band_sample_t filter_sample(band_sample_t item);
        band_sample_t result;
        longint       y;
        int           order;
        y = longint'($signed(item.sample));
        if (pass_through) begin
            // Bypass: pass the sample, wipe every delay word, mark the band inactive.
            for (int c = 0; c < CHANNEL_NUM; c++)
                for (int s = 0; s < SECTIONS; s++) begin
                    delay_s1[c][s] = '0;
                    delay_s2[c][s] = '0;
                end
            stages_in_use = 0;
        end else begin
            // Clamp the section count into 1..SECTIONS.
            order = int'(stage_count);
            if (order < 1) order = 1;
            if (order > SECTIONS) order = SECTIONS;
            // Sections that join the cascade start clean on every channel;
            // sections that drop out keep their history.
            for (int c = 0; c < CHANNEL_NUM; c++)
                for (int s = stages_in_use; s < order; s++) begin
                    delay_s1[c][s] = '0;
                    delay_s2[c][s] = '0;
                end
            stages_in_use = order;
            // A channel with no history slot passes through untouched.
            if (int'(item.channel) < CHANNEL_NUM)
                for (int s = 0; s < order; s++)
                    y = run_biquad(int'(item.channel), s, y);
        end
        result.sample  = y[SAMPLE_W-1:0];
        result.channel = item.channel;
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        int          v;
        r = $urandom_range(0, 99);
        v = int'($urandom_range(0, 1023)) - 512;
        if (r < 8)  return SAMPLE_MAX;
        if (r < 16) return SAMPLE_MIN;
        if (r < 40) return v[SAMPLE_W-1:0];
        return SAMPLE_W'($urandom);
    endfunction

    // Random Q3.28 coefficient, scaled down by an arithmetic shift.
    function automatic logic [COEF_W-1:0] pick_coef(int shift);
        logic signed [COEF_W-1:0] raw;
        raw = $urandom;
        return raw >>> shift;
    endfunction

    function automatic void queue_sample(logic [SAMPLE_W-1:0] sample, logic channel);
        band_sample_t item;
        item.sample  = sample;
        item.channel = channel;
        samples_to_send.push_back(item);
    endfunction

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[cycle %0d] %s: expected %h, got %h", cycle_count, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Register writes: only issued while the block is idle
    // ------------------------------------------------------------------

    task automatic write_reg(cfg_reg_t idx, logic [COEF_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        // Hold the request until the block takes it.
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_B0:     tap_b0 = value;
            REG_B1:     tap_b1 = value;
            REG_B2:     tap_b2 = value;
            REG_A1:     fb_a1  = value;
            REG_A2:     fb_a2  = value;
            REG_COUNT:  stage_count  = value[CNT_W-1:0];
            REG_BYPASS: pass_through = value[0];
            default: ;
        endcase
        // Leave the stimulus process on a falling edge, away from the driver.
        @(negedge aclk);
    endtask

    // Every item yields one result, so once nothing is queued or owed the block is idle.
    task automatic wait_drained();
        @(negedge aclk);
        while (samples_to_send.size() != 0 || filtered_due.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: offer the head of the queue, predict on each transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed_proc
        logic offer;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            feed_gap = 0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                // Transfer done: advance the prediction and drop the item.
                filtered_due.push_back(filter_sample(samples_to_send.pop_front()));
                offer = 1'b0;
                if (src_idle && $urandom_range(0, 2) == 0)
                    feed_gap = gap_length();
            end
            if (!offer) begin
                if (feed_gap != 0)
                    feed_gap--;
                else if (samples_to_send.size() != 0)
                    offer = 1'b1;
            end
            // A held item keeps valid high with no intervening low.
            s_axis_tvalid <= offer;
            if (offer) begin
                s_axis_tdata <= samples_to_send[0].sample;
                s_axis_tuser <= samples_to_send[0].channel;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, started by a rising hold_req
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : hold_proc
        hold_req_d <= hold_req;
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_req_d)
            hold_left <= LONG_HOLD;
    end

    // ------------------------------------------------------------------
    // Output monitor: check each transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : sink_proc
        band_sample_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_due.size() == 0) begin
                    flag_mismatch("result with nothing pending", 0,
                                  32'({m_axis_tuser, m_axis_tdata}));
                end else begin
                    want = filtered_due.pop_front();
                    if (m_axis_tdata !== want.sample)
                        flag_mismatch("sample_out", 32'(want.sample), 32'(m_axis_tdata));
                    if (m_axis_tuser !== want.channel)
                        flag_mismatch("channel_out", 32'(want.channel), 32'(m_axis_tuser));
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0)
                    sink_gap = gap_length();
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus_proc
        int count;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset leaves the band bypassed: extremes go straight through, both channels.
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b1);
        queue_sample('0, 1'b0);
        queue_sample('1, 1'b1);
        wait_drained();

        // Band comes back with unity b0 and one section: identity, from clean history.
        write_reg(REG_BYPASS, 32'd0);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b1);
        wait_drained();

        // Gain near 8 drives the output into both rails.
        write_reg(REG_B0, 32'h7FFF_FFFF);
        queue_sample(24'h40_0000, 1'b0);
        queue_sample(24'hC0_0000, 1'b1);
        wait_drained();

        // Count above the maximum clamps to four sections; the new ones start clean.
        write_reg(REG_B0, 32'h0800_0000);
        write_reg(REG_B1, 32'h1000_0000);
        write_reg(REG_A1, 32'h0800_0000);
        write_reg(REG_COUNT, 32'd7);
        queue_sample(24'h12_3456, 1'b0);
        queue_sample(24'hED_CBA9, 1'b1);
        queue_sample(24'h7F_0000, 1'b0);
        wait_drained();

        // Count of zero acts as one; shrinking keeps the history.
        write_reg(REG_COUNT, 32'd0);
        queue_sample(24'h00_1000, 1'b1);
        queue_sample(24'hFF_F000, 1'b0);
        wait_drained();

        // Grow to three: only sections two and three are cleared.
        write_reg(REG_COUNT, 32'd3);
        queue_sample(24'h20_0000, 1'b0);
        queue_sample(24'hE0_0000, 1'b1);
        wait_drained();

        write_reg(REG_B2, 32'h8000_0000);
        write_reg(REG_A2, 32'hF000_0000);
        queue_sample(24'h05_5555, 1'b1);
        queue_sample(24'hAA_AAAA, 1'b0);
        wait_drained();

        // Bypass wipes everything, then the band returns from zero history.
        write_reg(REG_BYPASS, 32'd1);
        queue_sample(24'h3C_3C3C, 1'b0);
        wait_drained();
        write_reg(REG_BYPASS, 32'd0);
        queue_sample(24'h3C_3C3C, 1'b0);
        queue_sample(24'hC3_C3C3, 1'b1);

        // Random phases: a fresh register setting each time, written only when idle.
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            src_idle  = (p % 3 != 1);
            sink_idle = (p % 4 != 2);
            case (p)
                1: begin
                    write_reg(REG_B0, 32'h7FFF_FFFF);
                    write_reg(REG_B1, 32'h7FFF_FFFF);
                    write_reg(REG_B2, 32'h7FFF_FFFF);
                    write_reg(REG_A1, 32'h7FFF_FFFF);
                    write_reg(REG_A2, 32'h7FFF_FFFF);
                end
                2: begin
                    write_reg(REG_B0, 32'h8000_0000);
                    write_reg(REG_B1, 32'h8000_0000);
                    write_reg(REG_B2, 32'h8000_0000);
                    write_reg(REG_A1, 32'h8000_0000);
                    write_reg(REG_A2, 32'h8000_0000);
                end
                default: begin
                    // Odd phases use the full range, even ones filter-like magnitudes.
                    write_reg(REG_B0, pick_coef((p % 2) ? 0 : 3));
                    write_reg(REG_B1, pick_coef((p % 2) ? 0 : 3));
                    write_reg(REG_B2, pick_coef((p % 2) ? 0 : 3));
                    write_reg(REG_A1, pick_coef((p % 2) ? 0 : 2));
                    write_reg(REG_A2, pick_coef((p % 2) ? 0 : 3));
                end
            endcase
            case (p)
                1:       count = 7;
                2:       count = 0;
                3:       count = 4;
                4:       count = 1;
                default: count = $urandom_range(0, 7);
            endcase
            write_reg(REG_COUNT, 32'(count));
            // One bypassed phase; the next brings the band back.
            write_reg(REG_BYPASS, (p == 5) ? 32'd1 : 32'd0);

            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_sample(pick_sample(), 1'($urandom_range(0, 1)));

            // Back-pressure: stall the output for a long stretch while the
            // sender keeps offering, so the block fills and stops taking input.
            if (p == 7) begin
                hold_req = 1'b1;
                wait (hold_left != 0);
                @(negedge aclk);
                hold_req = 1'b0;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && filtered_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
